>>> hdl/isort_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types and defaults for the insertion sorter and its cell chain.
// ----------------------------------------------------------------------------
package isort_pkg;

  // default configuration
  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the incoming value in the sorted row
    logic shift;   // move the row one place towards cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/isort_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isort_cell
// One element of the sorted row: compares itself with the incoming value and
// takes its left neighbour, the new value or its right neighbour.
// ----------------------------------------------------------------------------
module isort_cell #(
  parameter int unsigned DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire isort_pkg::cell_ctrl_t        ctrl,
  input  wire logic signed [DATA_WIDTH-1:0] new_value,
  input  wire logic signed [DATA_WIDTH-1:0] left_data,
  input  wire logic                         left_valid,
  input  wire logic                         left_gt,
  input  wire logic signed [DATA_WIDTH-1:0] right_data,
  input  wire logic                         right_valid,
  output logic signed [DATA_WIDTH-1:0]      data,
  output logic                              valid,
  output logic                              gt
);

  // an empty cell counts as larger than anything
  assign gt = !valid || (data > new_value);

  // update only where the new value or the shifted row lands
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      data  <= right_data;
      valid <= right_valid;
    end else if (ctrl.insert && gt && left_valid) begin
      data  <= left_gt ? left_data : new_value;
      valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/insertion_sorter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Stable insertion sorter built from a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Values enter one beat per cycle while no batch drains; every cell compares
// against the incoming value in parallel, so an insert does not depend on the
// fill level. A beat with tlast closes the batch: that value is inserted
// unless the row is full, then the row is drained from cell 0, one result beat
// per cycle while m_tready is high, the last result carrying tlast. No input is
// taken while the batch drains, so the next batch waits for the last result;
// at most CAPACITY values are stored.
// Values arriving while all CAPACITY cells are full are dropped and every
// result of that batch carries the overflow flag in m_tuser.
module insertion_sorter_unit #(
  parameter int unsigned CAPACITY   = isort_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isort_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
  input  wire logic                                 s_tlast,  // batch_end
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0]     m_tdata,  // sorted_value
  output logic                                      m_tlast,  // final_res
  output logic                                      m_tuser   // overflow
);

  logic signed [DATA_WIDTH-1:0] cell_data  [CAPACITY];
  logic                         cell_valid [CAPACITY];
  logic                         cell_gt    [CAPACITY];
  logic signed [DATA_WIDTH-1:0] new_value;
  isort_pkg::cell_ctrl_t        ctrl;
  logic                         draining;
  logic                         dropped;
  logic                         in_beat;
  logic                         out_beat;
  logic                         full;

  assign new_value = s_tdata[DATA_WIDTH-1:0];
  assign full      = cell_valid[CAPACITY-1];
  assign s_tready  = !draining;
  assign in_beat   = s_tvalid && s_tready;
  assign m_tvalid  = draining && cell_valid[0];
  assign out_beat  = m_tvalid && m_tready;

  assign ctrl.insert = in_beat && !full;
  assign ctrl.shift  = out_beat;

  // row of cells, neighbours wired left and right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] l_data;
    logic                         l_valid;
    logic                         l_gt;
    logic signed [DATA_WIDTH-1:0] r_data;
    logic                         r_valid;

    if (i == 0) begin : g_first
      assign l_data  = '0;
      assign l_valid = 1'b1;
      assign l_gt    = 1'b0;
    end else begin : g_inner_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    isort_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (new_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_gt     (l_gt),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // batch control: drain after the closing beat, track dropped values
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (out_beat && m_tlast) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (in_beat) begin
      draining <= s_tlast;
      if (full) begin
        dropped <= 1'b1;
      end
    end
  end

  // result beat straight from the head of the row
  always_comb begin
    m_tdata                   = '0;
    m_tdata[DATA_WIDTH-1:0]   = cell_data[0];
  end

  if (CAPACITY > 1) begin : g_tlast
    assign m_tlast = !cell_valid[1];
  end else begin : g_tlast_one
    assign m_tlast = 1'b1;
  end

  assign m_tuser = dropped;

endmodule

`default_nettype wire
